/* hw/rtl/ret_pkg.sv */
// ----------------------------------------------------------------------------
// ret_pkg : shared types and constants for the readiness event table
// Item codes, status codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ret_pkg;

  localparam int NUM_SOCKETS_DEF = 256;
  localparam int MAX_COLLECT_DEF = 64;

  localparam int KIND_W  = 3;
  localparam int SOCK_W  = 8;
  localparam int MASK_W  = 32;
  localparam int MAXEV_W = 7;

  localparam logic [MASK_W-1:0] ERR_BIT = 32'h0000_0008;
  localparam logic [MASK_W-1:0] HUP_BIT = 32'h0000_0010;

  typedef enum logic [KIND_W-1:0] {
    K_ADD     = 3'd0,
    K_DEL     = 3'd1,
    K_MOD     = 3'd2,
    K_REPORT  = 3'd3,
    K_COLLECT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_BADARG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_PATCH_RD,
    S_PATCH_WR,
    S_RESP,
    S_POP
  } state_t;

  typedef struct packed {
    status_t             status;
    logic                entry_valid;
    logic [SOCK_W-1:0]   sock;
    logic [MASK_W-1:0]   mask;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/ret_ram.sv */
// ----------------------------------------------------------------------------
// ret_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ret_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ret_ctrl.sv */
// ----------------------------------------------------------------------------
// ret_ctrl : sequencer for the interest table and ready list
// Read-modify-write of per-socket entries; ready list kept as a doubly
// linked stack threaded through the entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ret_ctrl #(
  parameter int NUM_SOCKETS = ret_pkg::NUM_SOCKETS_DEF,
  parameter int MAX_COLLECT = ret_pkg::MAX_COLLECT_DEF,
  localparam int IW = $clog2(NUM_SOCKETS),
  localparam int PW = IW + 1,
  localparam int EW = 2 + 2 * PW + ret_pkg::MASK_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ret_pkg::KIND_W-1:0]     kind,
  input  wire logic [ret_pkg::SOCK_W-1:0]     socket_id,
  input  wire logic [ret_pkg::MASK_W-1:0]     event_mask,
  input  wire logic [ret_pkg::MAXEV_W-1:0]    max_events,
  input  wire logic                           slot_free,
  output logic                                res_load,
  output ret_pkg::res_t                       res,
  output logic                                wr_en,
  output logic      [IW-1:0]                  wr_addr,
  output logic      [EW-1:0]                  wr_data,
  output logic                                rd_en,
  output logic      [IW-1:0]                  rd_addr,
  input  wire logic [EW-1:0]                  rd_data
);

  localparam int MW = ret_pkg::MASK_W;
  localparam logic [PW-1:0] NIL = {1'b1, {IW{1'b0}}};
  localparam logic [ret_pkg::MAXEV_W-1:0] MAXC = ret_pkg::MAXEV_W'(MAX_COLLECT);

  ret_pkg::state_t  state, state_next;
  ret_pkg::status_t st, st_next;
  logic [PW-1:0]    top, top_next;     // newest ready entry, MSB set = empty
  logic [PW-1:0]    pa, pa_next;       // neighbor above (newer)
  logic [PW-1:0]    pb, pb_next;       // neighbor below (older)
  logic             pend_a, pend_a_next;
  logic             pend_b, pend_b_next;
  logic [ret_pkg::MAXEV_W-1:0] remaining, remaining_next;
  logic [IW-1:0]    clr, clr_next;
  logic [ret_pkg::KIND_W-1:0] k_kind, k_kind_next;
  logic [IW-1:0]    k_addr, k_addr_next;
  logic [MW-1:0]    k_mask, k_mask_next;

  // entry fields of the word just read
  logic          e_reg, e_rdy, pop_last;
  logic [PW-1:0] e_above, e_below;
  logic [MW-1:0] e_mask;
  logic [IW+7:0] sock_ext;
  logic          in_range;

  assign e_reg   = rd_data[EW-1];
  assign e_rdy   = rd_data[EW-2];
  assign e_above = rd_data[2*PW+MW-1:PW+MW];
  assign e_below = rd_data[PW+MW-1:MW];
  assign e_mask  = rd_data[MW-1:0];

  assign sock_ext = (IW+8)'(socket_id);
  assign in_range = sock_ext < (IW+8)'(NUM_SOCKETS);
  assign pop_last = (remaining == ret_pkg::MAXEV_W'(1)) || e_below[IW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ret_pkg::S_CLEAR;
      top       <= NIL;
      pend_a    <= 1'b0;
      pend_b    <= 1'b0;
      clr       <= '0;
      remaining <= '0;
    end else begin
      state     <= state_next;
      top       <= top_next;
      pend_a    <= pend_a_next;
      pend_b    <= pend_b_next;
      clr       <= clr_next;
      remaining <= remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    st     <= st_next;
    pa     <= pa_next;
    pb     <= pb_next;
    k_kind <= k_kind_next;
    k_addr <= k_addr_next;
    k_mask <= k_mask_next;
  end

  always_comb begin
    state_next     = state;
    st_next        = st;
    top_next       = top;
    pa_next        = pa;
    pb_next        = pb;
    pend_a_next    = pend_a;
    pend_b_next    = pend_b;
    remaining_next = remaining;
    clr_next       = clr;
    k_kind_next    = k_kind;
    k_addr_next    = k_addr;
    k_mask_next    = k_mask;
    in_ready       = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = k_addr;
    wr_en          = 1'b0;
    wr_addr        = k_addr;
    wr_data        = rd_data;
    res_load       = 1'b0;
    res            = '{status: st, entry_valid: 1'b0, sock: '0, mask: '0, last: 1'b1};

    unique case (state)
      ret_pkg::S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = '0;
        clr_next = clr + IW'(1);
        if (clr == IW'(NUM_SOCKETS - 1)) begin
          state_next = ret_pkg::S_IDLE;
        end
      end

      ret_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          k_kind_next = kind;
          k_addr_next = sock_ext[IW-1:0];
          k_mask_next = event_mask;
          unique case (kind)
            ret_pkg::K_ADD, ret_pkg::K_DEL, ret_pkg::K_MOD, ret_pkg::K_REPORT: begin
              if (in_range) begin
                rd_en      = 1'b1;
                rd_addr    = sock_ext[IW-1:0];
                state_next = ret_pkg::S_EXEC;
              end else begin
                st_next    = ret_pkg::ST_BADARG;
                state_next = ret_pkg::S_RESP;
              end
            end
            ret_pkg::K_COLLECT: begin
              if (max_events == '0) begin
                st_next    = ret_pkg::ST_BADARG;
                state_next = ret_pkg::S_RESP;
              end else if (top[IW]) begin
                st_next    = ret_pkg::ST_OK;
                state_next = ret_pkg::S_RESP;
              end else begin
                remaining_next = (max_events > MAXC) ? MAXC : max_events;
                rd_en          = 1'b1;
                rd_addr        = top[IW-1:0];
                state_next     = ret_pkg::S_POP;
              end
            end
            default: begin
              st_next    = ret_pkg::ST_BADARG;
              state_next = ret_pkg::S_RESP;
            end
          endcase
        end
      end

      ret_pkg::S_EXEC: begin
        st_next = ret_pkg::ST_OK;
        unique case (k_kind)
          ret_pkg::K_ADD: begin
            if (e_reg) begin
              st_next = ret_pkg::ST_DUP;
            end else begin
              wr_en   = 1'b1;
              wr_data = {1'b1, 1'b0, NIL, NIL, k_mask};
            end
          end
          ret_pkg::K_DEL: begin
            if (!e_reg) begin
              st_next = ret_pkg::ST_ABSENT;
            end else begin
              wr_en   = 1'b1;
              wr_data = {1'b0, 1'b0, NIL, NIL, e_mask};
              if (e_rdy) begin
                // unlink: above.below <= below, below.above <= above
                pa_next = e_above;
                pb_next = e_below;
                if ({1'b0, k_addr} == top) begin
                  // the top's upper link may be stale after a pop
                  top_next = e_below;
                  pa_next  = NIL;
                end else begin
                  pend_a_next = 1'b1;
                end
                pend_b_next = !e_below[IW];
              end
            end
          end
          ret_pkg::K_MOD: begin
            if (!e_reg) begin
              st_next = ret_pkg::ST_ABSENT;
            end else begin
              wr_en   = 1'b1;
              wr_data = {1'b1, e_rdy, e_above, e_below,
                         k_mask | ret_pkg::ERR_BIT | ret_pkg::HUP_BIT};
            end
          end
          ret_pkg::K_REPORT: begin
            if (!e_reg) begin
              st_next = ret_pkg::ST_ABSENT;
            end else if (e_rdy) begin
              wr_en   = 1'b1;
              wr_data = {1'b1, 1'b1, e_above, e_below, e_mask | k_mask};
            end else begin
              // push on top; old top gets this entry as its upper neighbor
              wr_en    = 1'b1;
              wr_data  = {1'b1, 1'b1, NIL, top, e_mask};
              top_next = {1'b0, k_addr};
              if (!top[IW]) begin
                pend_b_next = 1'b1;
                pb_next     = top;
                pa_next     = {1'b0, k_addr};
              end
            end
          end
          default: begin
            st_next = ret_pkg::ST_BADARG;
          end
        endcase
        state_next = (pend_a_next || pend_b_next) ? ret_pkg::S_PATCH_RD : ret_pkg::S_RESP;
      end

      ret_pkg::S_PATCH_RD: begin
        rd_en      = 1'b1;
        rd_addr    = pend_a ? pa[IW-1:0] : pb[IW-1:0];
        state_next = ret_pkg::S_PATCH_WR;
      end

      ret_pkg::S_PATCH_WR: begin
        wr_en = 1'b1;
        if (pend_a) begin
          wr_addr     = pa[IW-1:0];
          wr_data     = {e_reg, e_rdy, e_above, pb, e_mask};
          pend_a_next = 1'b0;
          state_next  = pend_b ? ret_pkg::S_PATCH_RD : ret_pkg::S_RESP;
        end else begin
          wr_addr     = pb[IW-1:0];
          wr_data     = {e_reg, e_rdy, pa, e_below, e_mask};
          pend_b_next = 1'b0;
          state_next  = ret_pkg::S_RESP;
        end
      end

      ret_pkg::S_RESP: begin
        if (slot_free) begin
          res_load   = 1'b1;
          state_next = ret_pkg::S_IDLE;
        end
      end

      ret_pkg::S_POP: begin
        // rd_data holds the top entry; it is held while the output stalls
        if (slot_free) begin
          res_load       = 1'b1;
          res            = '{status: ret_pkg::ST_OK, entry_valid: 1'b1,
                             sock: ret_pkg::SOCK_W'(top[IW-1:0]), mask: e_mask,
                             last: pop_last};
          wr_en          = 1'b1;
          wr_addr        = top[IW-1:0];
          wr_data        = {e_reg, 1'b0, NIL, NIL, e_mask};
          top_next       = e_below;
          remaining_next = remaining - ret_pkg::MAXEV_W'(1);
          if (pop_last) begin
            state_next = ret_pkg::S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = e_below[IW-1:0];
          end
        end
      end

      default: begin
        state_next = ret_pkg::S_IDLE;
      end
    endcase
  end

  // never read and write the same entry in one cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && (wr_addr == rd_addr)))
    else $error("read and write of same entry in one cycle");

  // results only go out into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> slot_free)
    else $error("result loaded into busy output slot");

  // popping requires a non-empty ready list
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ret_pkg::S_POP) |-> !top[IW])
    else $error("pop from empty ready list");

  // the clearing pass follows reset and keeps the input closed
  a_clear_after_rst: assert property (@(posedge clk)
    $past(rst) |-> (state == ret_pkg::S_CLEAR && !in_ready))
    else $error("clearing pass not started after reset");

  // a patch is only pending while the patch sequence runs
  a_patch_scope: assert property (@(posedge clk) disable iff (rst)
    (state == ret_pkg::S_IDLE) |-> !(pend_a || pend_b))
    else $error("link patch left pending");

endmodule

`default_nettype wire

/* hw/rtl/readiness_event_table_top.sv */
// ----------------------------------------------------------------------------
// readiness_event_table_top : interest table with a LIFO ready list
// Per-socket entries (registered, ready, list links, mask) in one RAM;
// a sequencer performs add/delete/modify/report/collect on them.
// ----------------------------------------------------------------------------
//
//   channel | signals                                       | dir
//   --------+-----------------------------------------------+-----
//   in      | in_valid, in_ready, kind, socket_id,          | in
//           | event_mask, max_events                        |
//   out     | out_valid, out_ready, status, entry_valid,    | out
//           | ready_socket, ready_mask, last                |
//
// Steps: add/delete/modify/report go through read, update and result; a
//   rejected item, a zero-sized or an empty collect only gives a result. Delete
//   of a ready socket and a push onto a non-empty list add a read and a write
//   per link patch (up to 2). Collect starts, then returns one entry per cycle
//   unless the output stalls. One RAM port pair: one read, one write a cycle.
// Reset: synchronous; afterwards a clearing pass writes every entry, during
//   which in_ready is low.
// Stalls: one output register; the next item is taken while a result waits,
//   and the result and pop states hold while it is full and out_ready is low.
//
`timescale 1ns / 1ps
`default_nettype none

module readiness_event_table_top #(
  parameter int NUM_SOCKETS = ret_pkg::NUM_SOCKETS_DEF,
  parameter int MAX_COLLECT = ret_pkg::MAX_COLLECT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ret_pkg::KIND_W-1:0]    kind,
  input  wire logic [ret_pkg::SOCK_W-1:0]    socket_id,
  input  wire logic [ret_pkg::MASK_W-1:0]    event_mask,
  input  wire logic [ret_pkg::MAXEV_W-1:0]   max_events,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [1:0]                    status,
  output logic                               entry_valid,
  output logic      [ret_pkg::SOCK_W-1:0]    ready_socket,
  output logic      [ret_pkg::MASK_W-1:0]    ready_mask,
  output logic                               last
);

  localparam int IW = $clog2(NUM_SOCKETS);
  // entry word: registered, ready, above link, below link, mask
  localparam int EW = 2 + 2 * (IW + 1) + ret_pkg::MASK_W;

  logic          wr_en, rd_en, res_load, slot_free;
  logic [IW-1:0] wr_addr, rd_addr;
  logic [EW-1:0] wr_data, rd_data;
  ret_pkg::res_t res, out_res;
  logic          out_valid_next;

  ret_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SOCKETS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ret_ctrl #(
    .NUM_SOCKETS (NUM_SOCKETS),
    .MAX_COLLECT (MAX_COLLECT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .socket_id  (socket_id),
    .event_mask (event_mask),
    .max_events (max_events),
    .slot_free  (slot_free),
    .res_load   (res_load),
    .res        (res),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // output register: free when empty or being drained this cycle
  assign slot_free      = !out_valid || out_ready;
  assign out_valid_next = res_load || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign status       = out_res.status;
  assign entry_valid  = out_res.entry_valid;
  assign ready_socket = out_res.sock;
  assign ready_mask   = out_res.mask;
  assign last         = out_res.last;

endmodule

`default_nettype wire
